/* sv/crcfgc_pkg.sv */
// Shared types, constants and the byte-wide CRC-32 update for the frame CRC block.
package crcfgc_pkg;

   localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT      = 32'hFFFFFFFF;
   localparam int          COUNT_WIDTH   = 3;
   localparam logic [COUNT_WIDTH-1:0] TRAILER_BYTES = 3'd4;
   localparam logic [COUNT_WIDTH-1:0] COUNT_SAT     = 3'd5;

   // Mode codes of the configuration register
   localparam logic MODE_GENERATE = 1'b0;
   localparam logic MODE_CHECK    = 1'b1;

   // One finished frame result
   typedef struct packed {
      logic        short_frame;
      logic        crc_match;
      logic [31:0] crc_value;
   } result_type;

   // Reflected CRC-32 update over one byte, unrolls to an XOR network
   function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* sv/crcfgc_frame.sv */
// Per-frame CRC state, trailer window and byte count, with the result of a last byte.
module crcfgc_frame (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              data_byte,
   input  logic                    last_byte,
   input  logic                    check_mode,
   output crcfgc_pkg::result_type  result
);
   import crcfgc_pkg::*;

   logic [31:0]            crc_ff, crc_in;
   logic [31:0]            window_ff, window_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic [7:0]             feed_byte;
   logic                   feed_en;
   logic [31:0]            crc_next;
   logic [31:0]            window_next;
   logic [COUNT_WIDTH-1:0] count_next;
   logic [31:0]            crc_out;
   logic                   is_short;

   // Which byte goes into the CRC: the new one, or the one leaving the window
   always_comb begin
      if (check_mode == MODE_CHECK) begin
         feed_byte = window_ff[31:24];
         feed_en   = (count_ff >= TRAILER_BYTES);
      end else begin
         feed_byte = data_byte;
         feed_en   = 1'b1;
      end
      crc_next    = feed_en ? crc_feed(crc_ff, feed_byte) : crc_ff;
      window_next = {window_ff[23:0], data_byte};
      count_next  = (count_ff < COUNT_SAT) ? count_ff + 3'd1 : count_ff;
   end

   // Result fields for a last byte
   always_comb begin
      crc_out          = ~crc_next;
      is_short         = (count_next < COUNT_SAT);
      result.crc_value = crc_out;
      if (check_mode == MODE_CHECK) begin
         result.short_frame = is_short;
         result.crc_match   = !is_short && (window_next == crc_out);
      end else begin
         result.short_frame = 1'b0;
         result.crc_match   = 1'b0;
      end
   end

   // Advance on every request, start over after the last byte
   always_comb begin
      crc_in    = crc_ff;
      window_in = window_ff;
      count_in  = count_ff;
      if (step) begin
         if (last_byte) begin
            crc_in    = CRC_INIT;
            window_in = '0;
            count_in  = '0;
         end else begin
            crc_in    = crc_next;
            window_in = window_next;
            count_in  = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= CRC_INIT;
         window_ff <= '0;
         count_ff  <= '0;
      end else begin
         crc_ff    <= crc_in;
         window_ff <= window_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* sv/crc32_frame_generate_check.sv */
// Top level of the streaming CRC-32 frame generator and checker.
//
// Frames enter on the req_ channel one byte per request, req_tlast on the
// final byte. One result leaves on the rsp_ channel per frame: the final
// inverted reflected CRC-32 in rsp_tdata, match and short flags in rsp_tuser.
// csr_ writes the mode: 0 computes the CRC over every byte, 1 treats the last
// four bytes as a big-endian trailer and compares it with the CRC of the rest.
// Frames under five bytes in check mode report short_frame instead of a match.
// Write the mode only while no frame is in flight; csr_ready is always high.
//
// Throughput: one byte per cycle, set by the combinational byte-wide XOR
// network that updates the CRC register. Latency: the result is valid in the
// cycle after the last byte is accepted, held in one output register.
// When rsp_tready is low with a result waiting, req_tready drops until the
// result is taken; a result can be taken and a new byte accepted in the same
// cycle. Reset clears the frame state, the mode (to generate) and the output valid flag.
module crc32_frame_generate_check (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tlast,    // last_byte
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [31:0] crc_value
   output logic [1:0]  rsp_tuser,    // [0] crc_match, [1] short_frame
   // mode register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data      // [0] check_mode
);
   import crcfgc_pkg::*;

   logic       mode_ff, mode_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   result_type frame_result;
   logic       accept;

   assign csr_ready  = 1'b1;
   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   crcfgc_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .data_byte  (req_tdata),
      .last_byte  (req_tlast),
      .check_mode (mode_ff),
      .result     (frame_result)
   );

   // Mode register
   assign mode_in = (csr_valid && csr_ready) ? csr_data : mode_ff;

   // Output register: load on a last byte, empty when taken
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (rsp_tvalid && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (accept && req_tlast) begin
         out_valid_in = 1'b1;
         out_in       = frame_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_GENERATE;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.crc_value;
   assign rsp_tuser  = {out_ff.short_frame, out_ff.crc_match};

   // A short frame never reports a match
   a_short_no_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("short frame reported as matching");

   // Generate mode never raises the check flags
   a_generate_flags: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast && mode_ff == MODE_GENERATE) |=> (rsp_tuser == 2'b00))
      else $error("flags set in generate mode");

   // A last byte always yields a result in the next cycle
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> rsp_tvalid)
      else $error("last byte produced no result");

   // An empty output register never stalls the request side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output");

endmodule

/* verif/crc32_frame_generate_check_tb.sv */
// Self-checking testbench for the streaming CRC-32 frame generator and checker.
`timescale 1ns / 1ps

module crc32_frame_generate_check_tb;
   import crcfgc_pkg::*;

   localparam int RANDOM_BYTES  = 1800;
   localparam int PHASE_BYTES   = 150;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int DIR_ROWS      = 25;

   // One directed byte; the expected result is given only where typed is set
   typedef struct packed {
      logic        mode;
      logic [7:0]  data;
      logic        last;
      logic        typed;
      logic [31:0] crc_value;
      logic        crc_match;
      logic        short_frame;
   } dir_row_type;

   localparam dir_row_type [0:DIR_ROWS-1] DIRECTED = {
      // generate: single zero byte
      {MODE_GENERATE, 8'h00, 1'b1, 1'b1, 32'hD202EF8D, 1'b0, 1'b0},
      // generate: "123456789", the usual check string
      {MODE_GENERATE, 8'h31, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      {MODE_GENERATE, 8'h32, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      {MODE_GENERATE, 8'h33, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      {MODE_GENERATE, 8'h34, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      {MODE_GENERATE, 8'h35, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      {MODE_GENERATE, 8'h36, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      {MODE_GENERATE, 8'h37, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      {MODE_GENERATE, 8'h38, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      {MODE_GENERATE, 8'h39, 1'b1, 1'b1, 32'hCBF43926, 1'b0, 1'b0},
      // check: one-byte frame is short, nothing fed
      {MODE_CHECK, 8'h5A, 1'b1, 1'b1, 32'h0, 1'b0, 1'b1},
      // check: four bytes, still short, window full but nothing left it
      {MODE_CHECK, 8'hFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      {MODE_CHECK, 8'hFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      {MODE_CHECK, 8'hFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      {MODE_CHECK, 8'hFF, 1'b1, 1'b1, 32'h0, 1'b0, 1'b1},
      // check: shortest full frame with a good trailer
      {MODE_CHECK, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      {MODE_CHECK, 8'hD2, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      {MODE_CHECK, 8'h02, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      {MODE_CHECK, 8'hEF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      {MODE_CHECK, 8'h8D, 1'b1, 1'b1, 32'hD202EF8D, 1'b1, 1'b0},
      // check: full frame with a bad trailer
      {MODE_CHECK, 8'hFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      {MODE_CHECK, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      {MODE_CHECK, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      {MODE_CHECK, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      {MODE_CHECK, 8'h00, 1'b1, 1'b1, 32'hFF000000, 1'b0, 1'b0}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] data_byte
   logic        req_tlast  = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;            // [31:0] crc_value
   logic [1:0]  rsp_tuser;            // [0] crc_match, [1] short_frame
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_data   = 1'b0;    // [0] check_mode

   // Predictor state
   logic                   mode_now;
   logic [31:0]            crc_acc;
   logic [31:0]            tail_window;
   logic [COUNT_WIDTH-1:0] seen_count;
   result_type             pending_results[$];

   // Idle control shared by both sides
   logic quiet      = 1'b0;
   int   hold_token = 0;
   int   hold_seen  = 0;
   int   hold_left  = 0;

   int bytes_sent     = 0;
   int frames_checked = 0;
   int match_count    = 0;
   int short_count    = 0;
   int fail_count     = 0;

   crc32_frame_generate_check i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin : clock_gen
      forever #5 clock = ~clock;
   end

   initial begin : reset_gen
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin : watchdog
      #2_000_000;
      $display("[crc32_frame_generate_check] ERROR");
      $finish;
   end

   // Reflected CRC-32, one message bit at a time, lowest bit first
   function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b);
      logic [31:0] r;
      r = acc;
      for (int i = 0; i < 8; i++) begin
         r = (r >> 1) ^ ((r[0] ^ b[i]) ? CRC_POLY : 32'h0);
      end
      return r;
   endfunction

   function automatic void restart_frame();
      crc_acc     = CRC_INIT;
      tail_window = 32'h0;
      seen_count  = '0;
   endfunction

   // Advance the frame state by one byte; returns 1 with the result on a last byte
   function automatic logic frame_step(input logic [7:0] b, input logic l,
                                       output result_type r);
      r = '0;
      if (mode_now == MODE_CHECK) begin
         // only the byte pushed out of the trailer window is covered
         if (seen_count >= TRAILER_BYTES) crc_acc = crc_byte(crc_acc, tail_window[31:24]);
      end else begin
         crc_acc = crc_byte(crc_acc, b);
      end
      tail_window = {tail_window[23:0], b};
      if (seen_count < COUNT_SAT) seen_count = seen_count + 1'b1;
      if (!l) return 1'b0;
      r.crc_value = ~crc_acc;
      if (mode_now == MODE_CHECK) begin
         r.short_frame = seen_count < COUNT_SAT;
         r.crc_match   = !r.short_frame && (tail_window == r.crc_value);
      end
      restart_frame();
      return 1'b1;
   endfunction

   // Offer one byte, with random gaps, and wait for it to be taken
   task automatic push_byte(input logic [7:0] b, input logic l);
      while (!quiet && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Mode write, only with nothing in flight
   task automatic write_mode(input logic m);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mode_now = m;
   endtask

   // Random frame; in check mode mostly payload plus its own CRC as trailer
   task automatic send_random_frame(input int max_len);
      logic [7:0]  body[$];
      logic [31:0] sum;
      int          len;
      int          pick;
      int          k;
      result_type  res;
      len  = $urandom_range(max_len, 1);
      pick = $urandom_range(99);
      repeat (len) body.push_back(8'($urandom_range(255)));
      if (mode_now == MODE_CHECK && pick < 80) begin
         sum = CRC_INIT;
         foreach (body[i]) sum = crc_byte(sum, body[i]);
         sum = ~sum;
         body.push_back(sum[31:24]);
         body.push_back(sum[23:16]);
         body.push_back(sum[15:8]);
         body.push_back(sum[7:0]);
         // damage a few with one flipped bit
         if (pick >= 68) begin
            k = $urandom_range(body.size() - 1);
            body[k] = body[k] ^ (8'h01 << $urandom_range(7));
         end
      end
      foreach (body[i]) begin
         push_byte(body[i], i == body.size() - 1);
         if (frame_step(body[i], i == body.size() - 1, res)) pending_results.push_back(res);
      end
   endtask

   // Response side: check each result, stall at random or on a hold request
   always @(posedge clock) begin : response_sink
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected result crc %h tuser %b", $time, rsp_tdata,
                           rsp_tuser);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               frames_checked++;
               if (want.crc_match) match_count++;
               if (want.short_frame) short_count++;
               if (rsp_tdata !== want.crc_value || rsp_tuser[0] !== want.crc_match ||
                   rsp_tuser[1] !== want.short_frame) begin
                  if (fail_count < 10) begin
                     $display("%0t: frame %0d expected crc %h match %b short %b",
                              $time, frames_checked, want.crc_value, want.crc_match,
                              want.short_frame);
                     $display("%0t: frame %0d got crc %h match %b short %b",
                              $time, frames_checked, rsp_tdata, rsp_tuser[0], rsp_tuser[1]);
                  end
                  fail_count++;
               end
            end
         end
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet || ($urandom_range(99) >= 6);
         end
      end
   end

   // Request side: directed table, then random phases alternating the mode
   initial begin : stimulus
      int          phase;
      int          phase_start;
      logic        got;
      result_type  res;
      dir_row_type row;
      mode_now = MODE_GENERATE;
      restart_frame();
      @(posedge clock);
      while (reset) @(posedge clock);
      write_mode(MODE_GENERATE);

      for (int i = 0; i < DIR_ROWS; i++) begin
         row = DIRECTED[i];
         if (row.mode != mode_now) write_mode(row.mode);
         push_byte(row.data, row.last);
         got = frame_step(row.data, row.last, res);
         if (row.typed)
            pending_results.push_back({row.short_frame, row.crc_match, row.crc_value});
         else if (got)
            pending_results.push_back(res);
      end

      phase = 0;
      while (bytes_sent < DIR_ROWS + RANDOM_BYTES) begin
         write_mode((phase % 2 == 0) ? MODE_CHECK : MODE_GENERATE);
         if (phase == 1) quiet <= 1'b1;
         if (phase == 3) begin
            // park the receiver and keep offering small frames until input stalls
            hold_token <= hold_token + 1;
            repeat (12) send_random_frame(3);
         end
         if (phase == 5) begin
            // let everything drain before going on
            repeat (4) send_random_frame(12);
            drain_results();
         end
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES)
            send_random_frame(($urandom_range(99) < 88) ? 12 : 64);
         if (phase == 1) quiet <= 1'b0;
         phase++;
      end

      drain_results();
      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      $display("Sent %0d bytes over %0d phases; %0d frame results checked.", bytes_sent, phase,
               frames_checked);
      $display("Covered %0d good trailers, %0d short check frames, %0d failures.", match_count,
               short_count, fail_count);
      if (fail_count == 0) begin
         $display("[crc32_frame_generate_check] OK");
      end else begin
         $display("[crc32_frame_generate_check] ERROR");
      end
      $finish;
   end

endmodule
